// ===== rtl/bpt_pkg.sv =====
// shared types, constants and microcode program for the balance controller
package bpt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W      = 18;
    localparam int MUL_B_W      = 29;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int ERR_W        = 17;
    localparam int INTEG_W      = 29;
    localparam int INT_SUM_W    = 35;
    localparam int ACC_W        = 54;
    localparam int DEMAND_SHIFT = 23;
    localparam int TB_SHIFT     = 20;

    localparam int DT_Q16    = 655;
    localparam int INTEG_MAX = 167772160;

    localparam logic [ERR_W-1:0]          DEADBAND = ERR_W'(0);
    localparam logic signed [MUL_B_W-1:0] TB_RECIP = MUL_B_W'(671089);
    localparam logic signed [MUL_B_W-1:0] DT_OPND  = MUL_B_W'(DT_Q16);

    localparam logic [15:0] PROP_GAIN_DFLT     = 16'd384;
    localparam logic [14:0] FAULT_LIMIT_DFLT   = 15'd5760;
    localparam logic [14:0] CURRENT_LIMIT_DFLT = 15'd7680;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN,
        REG_INT_GAIN,
        REG_RATE_GAIN,
        REG_PITCH_FAULT_LIMIT,
        REG_ROLL_FAULT_LIMIT,
        REG_CURRENT_LIMIT,
        REG_TILTBACK_SPEED,
        REG_TILTBACK_ANGLE_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] int_gain;
        logic [15:0] rate_gain;
        logic [14:0] pitch_fault_limit;
        logic [14:0] roll_fault_limit;
        logic [14:0] current_limit;
        logic [14:0] tiltback_speed;
        logic [13:0] tiltback_angle_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:            16'd384,
        int_gain:             16'd0,
        rate_gain:            16'd0,
        pitch_fault_limit:    15'd5760,
        roll_fault_limit:     15'd5760,
        current_limit:        15'd7680,
        tiltback_speed:       15'd0,
        tiltback_angle_limit: 14'd0
    };

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_CK_SENS,
        ST_CK_TILT,
        ST_CK_PAD,
        ST_MUL_TILT,
        ST_TARGET,
        ST_ERROR,
        ST_MUL_DT,
        ST_INTEG,
        ST_ACC_P,
        ST_ACC_I,
        ST_ACC_D,
        ST_FIN_RUN,
        ST_FIN_SENS,
        ST_FIN_TILT,
        ST_FIN_REL
    } step_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_NO_BEAT,
        C_SENS,
        C_TILT,
        C_NOPAD,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [2:0] {
        M_NONE,
        M_TILT,
        M_DT,
        M_KP,
        M_KI,
        M_KD
    } mul_sel_t;

    typedef enum logic [1:0] {
        A_HOLD,
        A_LOAD16,
        A_ADD,
        A_ADD19
    } acc_op_t;

    typedef enum logic [2:0] {
        D_NONE,
        D_TARGET,
        D_ERR,
        D_INTEG,
        D_OUT
    } dst_t;

    typedef enum logic [1:0] {
        R_SENS,
        R_TILT,
        R_REL,
        R_RUN
    } res_t;

    typedef struct packed {
        logic     take;
        cond_t    cond;
        step_t    jmp;
        step_t    nxt;
        mul_sel_t mul;
        acc_op_t  acc;
        dst_t     dst;
        res_t     res;
    } ctrl_t;

    typedef struct packed {
        logic sens_fail;
        logic tilt_fault;
        logic no_pad;
        logic out_busy;
    } flags_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t cw;
        cw = '{take: 1'b0, cond: C_NONE, jmp: ST_WAIT, nxt: ST_WAIT, mul: M_NONE,
               acc: A_HOLD, dst: D_NONE, res: R_RUN};
        unique case (s)
            ST_WAIT:
            begin
                cw.take = 1'b1;
                cw.cond = C_NO_BEAT;
                cw.jmp  = ST_WAIT;
                cw.nxt  = ST_CK_SENS;
            end
            ST_CK_SENS:
            begin
                cw.cond = C_SENS;
                cw.jmp  = ST_FIN_SENS;
                cw.nxt  = ST_CK_TILT;
            end
            ST_CK_TILT:
            begin
                cw.cond = C_TILT;
                cw.jmp  = ST_FIN_TILT;
                cw.nxt  = ST_CK_PAD;
            end
            ST_CK_PAD:
            begin
                cw.cond = C_NOPAD;
                cw.jmp  = ST_FIN_REL;
                cw.nxt  = ST_MUL_TILT;
            end
            ST_MUL_TILT:
            begin
                cw.mul = M_TILT;
                cw.nxt = ST_TARGET;
            end
            ST_TARGET:
            begin
                cw.dst = D_TARGET;
                cw.nxt = ST_ERROR;
            end
            ST_ERROR:
            begin
                cw.dst = D_ERR;
                cw.nxt = ST_MUL_DT;
            end
            ST_MUL_DT:
            begin
                cw.mul = M_DT;
                cw.nxt = ST_INTEG;
            end
            ST_INTEG:
            begin
                cw.dst = D_INTEG;
                cw.mul = M_KP;
                cw.nxt = ST_ACC_P;
            end
            ST_ACC_P:
            begin
                cw.acc = A_LOAD16;
                cw.mul = M_KI;
                cw.nxt = ST_ACC_I;
            end
            ST_ACC_I:
            begin
                cw.acc = A_ADD;
                cw.mul = M_KD;
                cw.nxt = ST_ACC_D;
            end
            ST_ACC_D:
            begin
                cw.acc = A_ADD19;
                cw.nxt = ST_FIN_RUN;
            end
            ST_FIN_RUN:
            begin
                cw.cond = C_OUT_BUSY;
                cw.jmp  = ST_FIN_RUN;
                cw.nxt  = ST_WAIT;
                cw.dst  = D_OUT;
                cw.res  = R_RUN;
            end
            ST_FIN_SENS:
            begin
                cw.cond = C_OUT_BUSY;
                cw.jmp  = ST_FIN_SENS;
                cw.nxt  = ST_WAIT;
                cw.dst  = D_OUT;
                cw.res  = R_SENS;
            end
            ST_FIN_TILT:
            begin
                cw.cond = C_OUT_BUSY;
                cw.jmp  = ST_FIN_TILT;
                cw.nxt  = ST_WAIT;
                cw.dst  = D_OUT;
                cw.res  = R_TILT;
            end
            ST_FIN_REL:
            begin
                cw.cond = C_OUT_BUSY;
                cw.jmp  = ST_FIN_REL;
                cw.nxt  = ST_WAIT;
                cw.dst  = D_OUT;
                cw.res  = R_REL;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/bpt_seq.sv =====
// microcode sequencer: step counter, program lookup and conditional jumps
module bpt_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  bpt_pkg::flags_t  flags,
    output bpt_pkg::ctrl_t   ctrl
);
    import bpt_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  hit;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NONE:     hit = 1'b0;
            C_NO_BEAT:  hit = !in_valid;
            C_SENS:     hit = flags.sens_fail;
            C_TILT:     hit = flags.tilt_fault;
            C_NOPAD:    hit = flags.no_pad;
            C_OUT_BUSY: hit = flags.out_busy;
            default:    hit = 1'b0;
        endcase
        step_next = hit ? ctrl.jmp : ctrl.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/bpt_dp.sv =====
// datapath: input capture, shared multiplier, accumulator, controller state, result register
module bpt_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  bpt_pkg::ctrl_t     ctrl,
    input  bpt_pkg::cfg_t      cfg,
    output bpt_pkg::flags_t    flags,
    input  logic               in_valid,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] roll_angle,
    input  logic signed [15:0] pitch_rate,
    input  logic               pad_left,
    input  logic               pad_right,
    input  logic signed [15:0] wheel_rpm,
    input  logic               sensor_ok,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] current_demand,
    output logic               engaged,
    output logic               fault,
    output logic               status,
    output logic signed [14:0] tilt_target
);
    import bpt_pkg::*;

    localparam int DSH_W = ACC_W - DEMAND_SHIFT;
    localparam logic signed [INT_SUM_W-1:0] ISUM_MAX = INT_SUM_W'(INTEG_MAX);
    localparam logic signed [INT_SUM_W-1:0] ISUM_MIN = -ISUM_MAX;

    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        return v[15] ? 17'(-w) : 17'(w);
    endfunction

    logic signed [15:0] pitch_reg, roll_reg, rate_reg, rpm_reg;
    logic               pads_reg, ok_reg;
    logic               in_beat;

    logic [15:0] kp_eff;
    logic [14:0] pflim, rflim, ilim;
    logic [16:0] apitch, aroll, arpm, tb_diff;
    logic        tb_on;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    logic [15:0]        mag_raw;
    logic [13:0]        mag;
    logic [14:0]        mag15;
    logic signed [14:0] target_calc, target_reg;

    logic signed [ERR_W-1:0] err_calc, err_db, err_reg;
    logic [ERR_W-1:0]        err_mag;

    logic signed [INT_SUM_W-1:0] isum;
    logic signed [INTEG_W-1:0]   integ_calc, integ_reg, integ_next;

    logic signed [ACC_W-1:0] prod_ext, acc_reg, acc_next;
    logic signed [DSH_W-1:0] dsh, dlim;
    logic signed [15:0]      demand_calc;

    logic               out_wr;
    logic               out_valid_reg, out_valid_next;
    logic               fault_reg, fault_next;
    logic               pad_eng_reg, pad_eng_next;
    logic signed [15:0] demand_reg, demand_next;
    logic               status_reg, status_next;
    logic signed [14:0] target_out_reg, target_out_next;

    assign in_beat = ctrl.take && in_valid;

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pitch_reg <= pitch_angle;
            roll_reg  <= roll_angle;
            rate_reg  <= pitch_rate;
            rpm_reg   <= wheel_rpm;
            pads_reg  <= pad_left | pad_right;
            ok_reg    <= sensor_ok;
        end
    end

    // zero proportional-gain, fault-limit and current-limit registers fall back to their defaults
    assign kp_eff = (cfg.prop_gain == '0) ? PROP_GAIN_DFLT : cfg.prop_gain;
    assign pflim  = (cfg.pitch_fault_limit == '0) ? FAULT_LIMIT_DFLT : cfg.pitch_fault_limit;
    assign rflim  = (cfg.roll_fault_limit == '0) ? FAULT_LIMIT_DFLT : cfg.roll_fault_limit;
    assign ilim   = (cfg.current_limit == '0) ? CURRENT_LIMIT_DFLT : cfg.current_limit;

    assign apitch  = mag17(pitch_reg);
    assign aroll   = mag17(roll_reg);
    assign arpm    = mag17(rpm_reg);
    assign tb_on   = (cfg.tiltback_speed != '0) && (arpm > {2'b00, cfg.tiltback_speed});
    assign tb_diff = arpm - {2'b00, cfg.tiltback_speed};

    assign flags.sens_fail  = !ok_reg;
    assign flags.tilt_fault = (apitch > {2'b00, pflim}) || (aroll > {2'b00, rflim});
    assign flags.no_pad     = !pads_reg;
    assign flags.out_busy   = out_valid_reg && out_stall;

    always_comb
    begin
        unique case (ctrl.mul)
            M_TILT:
            begin
                mul_a = $signed({1'b0, tb_diff});
                mul_b = TB_RECIP;
            end
            M_DT:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = DT_OPND;
            end
            M_KP:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(kp_eff);
            end
            M_KI:
            begin
                mul_a = MUL_A_W'(cfg.int_gain);
                mul_b = MUL_B_W'(integ_reg);
            end
            M_KD:
            begin
                mul_a = MUL_A_W'(rate_reg);
                mul_b = MUL_B_W'(cfg.rate_gain);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul != M_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // tiltback: 0.64 per excess rpm by reciprocal multiply
    assign mag_raw     = prod_reg[TB_SHIFT+15:TB_SHIFT];
    assign mag         = (mag_raw > {2'b00, cfg.tiltback_angle_limit})
                         ? cfg.tiltback_angle_limit : mag_raw[13:0];
    assign mag15       = {1'b0, mag};
    assign target_calc = !tb_on ? '0 : (rpm_reg[15] ? 15'(15'd0 - mag15) : mag15);

    assign err_calc = ERR_W'(pitch_reg) - ERR_W'(target_reg);
    assign err_mag  = err_calc[ERR_W-1] ? ERR_W'(-err_calc) : ERR_W'(err_calc);
    assign err_db   = (err_mag < DEADBAND) ? '0 : err_calc;

    always_ff @(posedge clk)
    begin
        if (ctrl.dst == D_TARGET)
        begin
            target_reg <= target_calc;
        end
        if (ctrl.dst == D_ERR)
        begin
            err_reg <= err_db;
        end
    end

    // anti-windup clamp
    assign isum = INT_SUM_W'(integ_reg) + INT_SUM_W'(prod_reg);

    always_comb
    begin
        if (isum > ISUM_MAX)
        begin
            integ_calc = INTEG_W'(ISUM_MAX);
        end
        else if (isum < ISUM_MIN)
        begin
            integ_calc = INTEG_W'(ISUM_MIN);
        end
        else
        begin
            integ_calc = INTEG_W'(isum);
        end
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        unique case (ctrl.acc)
            A_HOLD:   acc_next = acc_reg;
            A_LOAD16: acc_next = prod_ext <<< 16;
            A_ADD:    acc_next = acc_reg + prod_ext;
            A_ADD19:  acc_next = acc_reg + (prod_ext <<< 19);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // floor to 1/256 A, then current clamp
    assign dsh  = $signed(acc_reg[ACC_W-1:DEMAND_SHIFT]);
    assign dlim = DSH_W'(ilim);

    always_comb
    begin
        if (dsh > dlim)
        begin
            demand_calc = 16'(dlim);
        end
        else if (dsh < -dlim)
        begin
            demand_calc = 16'(-dlim);
        end
        else
        begin
            demand_calc = 16'(dsh);
        end
    end

    assign out_wr = (ctrl.dst == D_OUT) && !flags.out_busy;

    always_comb
    begin
        fault_next      = fault_reg;
        pad_eng_next    = pad_eng_reg;
        integ_next      = integ_reg;
        demand_next     = demand_reg;
        status_next     = status_reg;
        target_out_next = target_out_reg;
        if (ctrl.dst == D_INTEG)
        begin
            integ_next = integ_calc;
        end
        if (out_wr)
        begin
            demand_next     = '0;
            status_next     = 1'b0;
            target_out_next = '0;
            unique case (ctrl.res)
                R_SENS:
                begin
                    fault_next  = 1'b1;
                    status_next = 1'b1;
                end
                R_TILT:
                begin
                    fault_next   = 1'b1;
                    pad_eng_next = pads_reg;
                    integ_next   = '0;
                end
                R_REL:
                begin
                    fault_next   = 1'b0;
                    pad_eng_next = 1'b0;
                    integ_next   = '0;
                end
                R_RUN:
                begin
                    fault_next      = 1'b0;
                    pad_eng_next    = 1'b1;
                    demand_next     = demand_calc;
                    target_out_next = target_reg;
                end
                default:
                begin
                    fault_next = fault_reg;
                end
            endcase
        end
        out_valid_next = out_wr ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fault_reg     <= 1'b0;
            pad_eng_reg   <= 1'b0;
            integ_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
            pad_eng_reg   <= pad_eng_next;
            integ_reg     <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        demand_reg     <= demand_next;
        status_reg     <= status_next;
        target_out_reg <= target_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign current_demand = demand_reg;
    assign engaged        = pad_eng_reg && !fault_reg;
    assign fault          = fault_reg;
    assign status         = status_reg;
    assign tilt_target    = target_out_reg;

endmodule

// ===== rtl/balance_pid_with_tiltback_top.sv =====
// top level of the balance controller: configuration registers, sequencer and datapath
//
// Balance PID with speed tiltback for a self-balancing board. One attitude sample per beat
// gives one current demand beat. A short microcode program steps a datapath built around a
// single shared 18x29 multiplier, one control word per clock. A normal sample steps from
// accept to the next accept through three check steps, the tiltback multiply,
// target and error steps, then the integral, proportional, integral-gain and rate-gain
// products passing through the one multiplier and accumulator, and a result step. A
// sensor failure, a tilt fault or a footpad release skips to its own result step. The result
// step waits while the previous result is still held by out_stall; a new sample is taken
// as soon as the result register is loaded. Configuration writes take effect at once and
// are to be made only while no sample is in flight; the block does not enforce it.
module balance_pid_with_tiltback_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [15:0]               pitch_angle,
    input  logic signed [15:0]               roll_angle,
    input  logic signed [15:0]               pitch_rate,
    input  logic                             pad_left,
    input  logic                             pad_right,
    input  logic signed [15:0]               wheel_rpm,
    input  logic                             sensor_ok,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [15:0]               current_demand,
    output logic                             engaged,
    output logic                             fault,
    output logic                             status,
    output logic signed [14:0]               tilt_target
);
    import bpt_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    ctrl_t  ctrl;
    flags_t flags;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:            cfg_next.prop_gain            = cfg_data;
                REG_INT_GAIN:             cfg_next.int_gain             = cfg_data;
                REG_RATE_GAIN:            cfg_next.rate_gain            = cfg_data;
                REG_PITCH_FAULT_LIMIT:    cfg_next.pitch_fault_limit    = cfg_data[14:0];
                REG_ROLL_FAULT_LIMIT:     cfg_next.roll_fault_limit     = cfg_data[14:0];
                REG_CURRENT_LIMIT:        cfg_next.current_limit        = cfg_data[14:0];
                REG_TILTBACK_SPEED:       cfg_next.tiltback_speed       = cfg_data[14:0];
                REG_TILTBACK_ANGLE_LIMIT: cfg_next.tiltback_angle_limit = cfg_data[13:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = !ctrl.take;

    bpt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    bpt_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg_reg),
        .flags          (flags),
        .in_valid       (in_valid),
        .pitch_angle    (pitch_angle),
        .roll_angle     (roll_angle),
        .pitch_rate     (pitch_rate),
        .pad_left       (pad_left),
        .pad_right      (pad_right),
        .wheel_rpm      (wheel_rpm),
        .sensor_ok      (sensor_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_demand (current_demand),
        .engaged        (engaged),
        .fault          (fault),
        .status         (status),
        .tilt_target    (tilt_target)
    );

`ifndef NO_ASSERTIONS
    a_engaged_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && engaged |-> !fault)
        else $error("engaged while faulted");

    a_demand_needs_engaged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (current_demand != 16'sd0) |-> engaged)
        else $error("nonzero demand while disengaged");

    a_status_sets_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> fault)
        else $error("sensor error without fault");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("sequencer took a second beat without running its program");
`endif

endmodule
